@@ rtl/ffill_pkg.sv @@
// shared types and constants of the flood fill block
package ffill_pkg;

  localparam int CFG_W     = 18;
  localparam int DIST_W    = 18;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
  localparam logic [6:0]         SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_RED   = 3'd0,
    REG_FILL_GREEN = 3'd1,
    REG_FILL_BLUE  = 3'd2,
    REG_TOLERANCE  = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_HEIGHT     = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_CLEAR,
    S_SEED,
    S_SEED_WAIT,
    S_POP,
    S_POP_WAIT,
    S_LOAD,
    S_DIST,
    S_PUSH,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

@@ rtl/ffill_if.sv @@
// valid/ready channel interfaces for commands and results
interface ffill_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] x;
  logic [5:0] y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, command, x, y, red, green, blue, input ready);
  modport sink (input valid, command, x, y, red, green, blue, output ready);
endinterface

interface ffill_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_red;
  logic [7:0]  pixel_green;
  logic [7:0]  pixel_blue;
  logic [12:0] filled_count;
  logic [1:0]  status;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, filled_count, status,
                  input ready);
  modport sink (input valid, pixel_red, pixel_green, pixel_blue, filled_count, status,
                output ready);
endinterface

@@ rtl/flood_fill_tolerance.sv @@
// flood fill top level: image store, visited map, worklist stack and sequencer
// write and out-of-image commands are done at accept; a read passes through S_RD_WAIT before its result is loaded
// a fill first clears the whole visited map, then handles each popped pixel: one already visited is
// skipped, one out of tolerance is dropped after the distance, one in tolerance is painted and pushed on
// its neighbours; the pace is set by the worklist stack, one access at a time, and the shared one-channel squarer
// reset is asynchronous active low; it clears control state and the configuration registers
module flood_fill_tolerance import ffill_pkg::*; #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_HEIGHT     = 64,
  parameter int WORKLIST_DEPTH = 16384
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  ffill_in_if.sink             in_i,
  ffill_out_if.source          out_o
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int SW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int EW     = XW + YW;
  localparam int LW     = $clog2(WORKLIST_DEPTH);
  localparam int PW     = $clog2(WORKLIST_DEPTH + 1);

  // configuration registers
  logic [7:0]        fill_red_q, fill_green_q, fill_blue_q;
  logic [DIST_W-1:0] tolerance_q;
  logic [6:0]        width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_red_q   <= '0;
      fill_green_q <= '0;
      fill_blue_q  <= '0;
      tolerance_q  <= '0;
      width_q      <= SIZE_RESET;
      height_q     <= SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FILL_RED:   fill_red_q   <= cfg_data_i[7:0];
        REG_FILL_GREEN: fill_green_q <= cfg_data_i[7:0];
        REG_FILL_BLUE:  fill_blue_q  <= cfg_data_i[7:0];
        REG_TOLERANCE:  tolerance_q  <= cfg_data_i[DIST_W-1:0];
        REG_WIDTH:      width_q      <= cfg_data_i[6:0];
        REG_HEIGHT:     height_q     <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective image size
  logic [SW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_q == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  function automatic logic [AW-1:0] pix_addr(logic [XW-1:0] cx, logic [YW-1:0] cy);
    return AW'(32'(cy) * 32'(MAX_WIDTH) + 32'(cx));
  endfunction

  // state
  fsm_e              state_q, state_d;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [AW-1:0]     clr_q, clr_d;
  dir_e              dir_q, dir_d;
  status_e           status_q, status_d;
  logic [XW-1:0]     cur_x_q, cur_x_d;
  logic [YW-1:0]     cur_y_q, cur_y_d;
  rgb_t              seed_q, seed_d;

  // memory ports
  logic          img_we, img_re;
  logic [AW-1:0] img_waddr, img_raddr;
  rgb_t          img_wdata, img_rdata_q;
  logic          vis_we, vis_re, vis_wdata, vis_rdata_q;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic          wl_we, wl_re;
  logic [LW-1:0] wl_waddr, wl_raddr;
  logic [EW-1:0] wl_wdata, wl_rdata_q;

  rgb_t img_mem [PIXELS];
  logic vis_mem [PIXELS];
  logic [EW-1:0] wl_mem [WORKLIST_DEPTH];

  always_ff @(posedge clk_i) begin
    if (img_we) img_mem[img_waddr] <= img_wdata;
    if (img_re) img_rdata_q <= img_mem[img_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (vis_re) vis_rdata_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wl_we) wl_mem[wl_waddr] <= wl_wdata;
    if (wl_re) wl_rdata_q <= wl_mem[wl_raddr];
  end

  // command decode
  logic          in_acc, in_range, out_free;
  cmd_e          cmd;
  logic [XW-1:0] in_x;
  logic [YW-1:0] in_y;
  logic [AW-1:0] in_addr, cur_addr, pop_addr;
  logic [XW-1:0] pop_x;
  logic [YW-1:0] pop_y;
  rgb_t          paint;

  assign cmd      = cmd_e'(in_i.command);
  assign out_free = !out_o.valid || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign in_range = (32'(in_i.x) < 32'(w_eff)) && (32'(in_i.y) < 32'(h_eff));
  assign in_x     = XW'(in_i.x);
  assign in_y     = YW'(in_i.y);
  assign in_addr  = pix_addr(in_x, in_y);
  assign cur_addr = pix_addr(cur_x_q, cur_y_q);
  assign pop_x    = wl_rdata_q[XW-1:0];
  assign pop_y    = wl_rdata_q[EW-1:XW];
  assign pop_addr = pix_addr(pop_x, pop_y);
  assign paint    = '{red: fill_red_q, green: fill_green_q, blue: fill_blue_q};

  // neighbour of the current pixel for this push step
  logic          nb_ok, wl_full;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;

  always_comb begin
    nb_x = cur_x_q;
    nb_y = cur_y_q;
    unique case (dir_q)
      DIR_RIGHT: begin
        nb_ok = (32'(cur_x_q) + 32'd1) < 32'(w_eff);
        nb_x  = cur_x_q + XW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (32'(cur_y_q) + 32'd1) < 32'(h_eff);
        nb_y  = cur_y_q + YW'(1);
      end
      DIR_LEFT: begin
        nb_ok = cur_x_q != '0;
        nb_x  = cur_x_q - XW'(1);
      end
      default: begin
        nb_ok = cur_y_q != '0;
        nb_y  = cur_y_q - YW'(1);
      end
    endcase
  end

  assign wl_full = ptr_q == PW'(WORKLIST_DEPTH);

  // shared distance unit
  logic              dist_start, dist_done, in_tol;
  logic [DIST_W-1:0] dist_val;

  ffill_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .pixel_i (img_rdata_q),
    .seed_i  (seed_q),
    .done_o  (dist_done),
    .dist_o  (dist_val)
  );

  assign in_tol = dist_val <= tolerance_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_range && cmd == CMD_READ) state_d = S_RD_WAIT;
        else if (in_acc && in_range && cmd == CMD_FILL) state_d = S_CLEAR;
      end
      S_RD_WAIT:   state_d = S_IDLE;
      S_CLEAR:     if (clr_q == AW'(PIXELS - 1)) state_d = S_SEED;
      S_SEED:      state_d = S_SEED_WAIT;
      S_SEED_WAIT: state_d = S_POP;
      S_POP:       state_d = (ptr_q == '0) ? S_DONE : S_POP_WAIT;
      S_POP_WAIT:  state_d = S_LOAD;
      S_LOAD:      state_d = vis_rdata_q ? S_POP : S_DIST;
      S_DIST:      if (dist_done) state_d = in_tol ? S_PUSH : S_POP;
      S_PUSH: begin
        if (nb_ok && wl_full) state_d = S_DONE;
        else if (dir_q == DIR_UP) state_d = S_POP;
      end
      S_DONE:      state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    img_we     = 1'b0;
    img_waddr  = cur_addr;
    img_wdata  = paint;
    img_re     = 1'b0;
    img_raddr  = cur_addr;
    vis_we     = 1'b0;
    vis_waddr  = cur_addr;
    vis_wdata  = 1'b1;
    vis_re     = 1'b0;
    vis_raddr  = pop_addr;
    wl_we      = 1'b0;
    wl_waddr   = ptr_q[LW-1:0];
    wl_wdata   = {nb_y, nb_x};
    wl_re      = 1'b0;
    wl_raddr   = LW'(ptr_q - PW'(1));
    ptr_d      = ptr_q;
    count_d    = count_q;
    clr_d      = clr_q;
    dir_d      = dir_q;
    status_d   = status_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    seed_d     = seed_q;
    dist_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_range) begin
          unique case (cmd)
            CMD_WRITE: begin
              img_we    = 1'b1;
              img_waddr = in_addr;
              img_wdata = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
            end
            CMD_READ: begin
              img_re    = 1'b1;
              img_raddr = in_addr;
            end
            CMD_FILL: begin
              cur_x_d  = in_x;
              cur_y_d  = in_y;
              clr_d    = '0;
              ptr_d    = '0;
              count_d  = '0;
              status_d = ST_OK;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
      end
      S_SEED: img_re = 1'b1;
      S_SEED_WAIT: begin
        seed_d   = img_rdata_q;
        wl_we    = 1'b1;
        wl_wdata = {cur_y_q, cur_x_q};
        ptr_d    = ptr_q + PW'(1);
      end
      S_POP: begin
        if (ptr_q != '0) begin
          wl_re = 1'b1;
          ptr_d = ptr_q - PW'(1);
        end
      end
      S_POP_WAIT: begin
        cur_x_d   = pop_x;
        cur_y_d   = pop_y;
        img_re    = 1'b1;
        img_raddr = pop_addr;
        vis_re    = 1'b1;
      end
      S_LOAD: dist_start = !vis_rdata_q;
      S_DIST: begin
        if (dist_done && in_tol) begin
          img_we = 1'b1;
          vis_we = 1'b1;
          if (count_q != COUNT_MAX) count_d = count_q + COUNT_W'(1);
          dir_d  = DIR_RIGHT;
        end
      end
      S_PUSH: begin
        if (nb_ok) begin
          if (wl_full) begin
            status_d = ST_OVERFLOW;
          end else begin
            wl_we = 1'b1;
            ptr_d = ptr_q + PW'(1);
          end
        end
        dir_d = dir_e'(dir_q + 2'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      count_q  <= '0;
      clr_q    <= '0;
      dir_q    <= DIR_RIGHT;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      count_q  <= count_d;
      clr_q    <= clr_d;
      dir_q    <= dir_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    seed_q  <= seed_d;
  end

  // result register
  logic               out_valid_q, load_range, load_read, load_fill;
  rgb_t               out_rgb_q;
  logic [COUNT_W-1:0] out_count_q;
  status_e            out_status_q;

  assign load_range = in_acc && !in_range && (cmd == CMD_READ || cmd == CMD_FILL);
  assign load_read  = state_q == S_RD_WAIT;
  assign load_fill  = state_q == S_DONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && !out_o.ready) || load_range || load_read || load_fill;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_range) begin
      out_rgb_q    <= '0;
      out_count_q  <= '0;
      out_status_q <= ST_RANGE;
    end else if (load_read) begin
      out_rgb_q    <= img_rdata_q;
      out_count_q  <= '0;
      out_status_q <= ST_OK;
    end else if (load_fill) begin
      out_rgb_q    <= '0;
      out_count_q  <= count_q;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_red    = out_rgb_q.red;
  assign out_o.pixel_green  = out_rgb_q.green;
  assign out_o.pixel_blue   = out_rgb_q.blue;
  assign out_o.filled_count = out_count_q;
  assign out_o.status       = out_status_q;

`ifndef ASSERT_OFF
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PW'(WORKLIST_DEPTH)) else $error("worklist pointer past depth");
  a_empty_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP && ptr_q == '0 |=> state_q == S_DONE) else $error("empty pop not done");
  a_dist_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_done |-> state_q == S_DIST) else $error("distance result outside wait");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wl_we |-> !wl_full) else $error("push into full worklist");
`endif

endmodule

@@ rtl/ffill_dist.sv @@
// squared rgb distance, one channel per cycle through a shared squarer
module ffill_dist import ffill_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rgb_t              pixel_i,
  input  rgb_t              seed_i,
  output logic              done_o,
  output logic [DIST_W-1:0] dist_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  chan_e             chan_q, chan_d;
  logic [DIST_W-1:0] acc_q, acc_d;
  logic [7:0]        op_a, op_b, diff;
  logic [15:0]       sq;

  // operand select for the current channel
  always_comb begin
    unique case (chan_q)
      CH_RED: begin
        op_a = pixel_i.red;
        op_b = seed_i.red;
      end
      CH_GREEN: begin
        op_a = pixel_i.green;
        op_b = seed_i.green;
      end
      default: begin
        op_a = pixel_i.blue;
        op_b = seed_i.blue;
      end
    endcase
  end

  // absolute difference and square
  assign diff = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
  assign sq   = 16'(diff) * 16'(diff);

  // channel sequencer and accumulator
  always_comb begin
    busy_d = busy_q;
    chan_d = chan_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      chan_d = CH_RED;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + DIST_W'(sq);
      if (chan_q == CH_BLUE) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        chan_d = chan_e'(chan_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      chan_q <= CH_RED;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      chan_q <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("distance start while busy");
  a_done_after_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(chan_q) == CH_BLUE) else $error("early done");
  a_three_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##2 done_d) else $error("distance not three cycles");
`endif

endmodule
